@@ rtl/fhc_pkg.sv @@
// Package for the field heatmap colormap: widths, colormap stops and the
// record that travels from the front end to the back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fhc_pkg;
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 10;
    localparam int PEAK_BITS     = 16;
    localparam int TAG_BITS      = 8;
    localparam int MODE_BITS     = 2;
    localparam int FS_BITS       = 15;
    localparam int CFG_IDX_BITS  = 1;

    // Signed working width that holds a sample, full scale and their sum.
    localparam int CW = ((SAMPLE_BITS > PEAK_BITS) ? SAMPLE_BITS : PEAK_BITS) + 2;
    // Divider remainder width.
    localparam int RW = CW + FRACTION_BITS;
    // Divider step counter width; one step per quotient bit.
    localparam int STEPS = FRACTION_BITS + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FS   = 1'd1;

    localparam logic [MODE_BITS-1:0] MODE_JET     = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_VIRIDIS = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_PLASMA  = 2'd2;

    localparam logic [TAG_BITS-1:0] TAG_GREY = 8'd1;
    localparam logic [TAG_BITS-1:0] TAG_BLUE = 8'd2;

    localparam logic [FS_BITS-1:0] FS_RESET = 15'd32767;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    localparam t_rgb VIRIDIS [0:4] = '{
        '{8'd68, 8'd1, 8'd84}, '{8'd59, 8'd82, 8'd139}, '{8'd33, 8'd144, 8'd141},
        '{8'd94, 8'd201, 8'd98}, '{8'd253, 8'd231, 8'd37}};
    localparam t_rgb PLASMA [0:4] = '{
        '{8'd13, 8'd8, 8'd135}, '{8'd84, 8'd3, 8'd163}, '{8'd139, 8'd10, 8'd165},
        '{8'd190, 8'd55, 8'd123}, '{8'd240, 8'd249, 8'd33}};
    localparam t_rgb RGB_GREY = '{8'd200, 8'd200, 8'd200};
    localparam t_rgb RGB_BLUE = '{8'd120, 8'd180, 8'd200};

    typedef struct packed {
        logic [CW-1:0]        offset;
        logic [TAG_BITS-1:0]  tag;
        logic [PEAK_BITS-1:0] peak;
    } t_job;
endpackage
`default_nettype wire

@@ rtl/fhc_in_if.sv @@
// Input channel of the heatmap colormap: handshake and sample beat.
// Depends on fhc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface fhc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [fhc_pkg::SAMPLE_BITS-1:0] field_value;
    logic [fhc_pkg::TAG_BITS-1:0]        cell_tag;
    logic                                frame_start;
    modport source (output valid, field_value, cell_tag, frame_start, input ready);
    modport sink (input valid, field_value, cell_tag, frame_start, output ready);
endinterface
`default_nettype wire

@@ rtl/fhc_out_if.sv @@
// Output channel of the heatmap colormap: handshake and pixel beat.
// Depends on fhc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface fhc_out_if;
    logic                          valid;
    logic                          ready;
    logic [7:0]                    red;
    logic [7:0]                    green;
    logic [7:0]                    blue;
    logic [fhc_pkg::PEAK_BITS-1:0] peak_magnitude;
    modport source (output valid, red, green, blue, peak_magnitude, input ready);
    modport sink (input valid, red, green, blue, peak_magnitude, output ready);
endinterface
`default_nettype wire

@@ rtl/fhc_front.sv @@
// Front end: accepts sample beats, tracks the frame peak and clamps the
// sample into an offset against full scale. Depends on fhc_pkg, fhc_in_if.
`timescale 1ns / 1ps
`default_nettype none
module fhc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    fhc_in_if.sink                             i_pix,
    input  wire logic [fhc_pkg::FS_BITS-1:0]   i_full_scale,
    input  wire logic                          i_full,
    output logic                               o_push,
    output fhc_pkg::t_job                      o_job
);
    logic [fhc_pkg::PEAK_BITS-1:0] r_peak;
    logic [fhc_pkg::PEAK_BITS-1:0] n_peak;
    logic signed [fhc_pkg::CW-1:0] sv;
    logic signed [fhc_pkg::CW-1:0] fsv;
    logic signed [fhc_pkg::CW-1:0] vc;
    logic [fhc_pkg::CW-1:0]        mag;
    logic [fhc_pkg::PEAK_BITS-1:0] mag_sat;

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    always_comb begin
        sv  = fhc_pkg::CW'(i_pix.field_value);
        fsv = signed'(fhc_pkg::CW'(i_full_scale));
        mag = (sv < 0) ? fhc_pkg::CW'(-sv) : fhc_pkg::CW'(sv);
        if (mag > fhc_pkg::CW'({fhc_pkg::PEAK_BITS{1'b1}})) begin
            mag_sat = {fhc_pkg::PEAK_BITS{1'b1}};
        end else begin
            mag_sat = mag[fhc_pkg::PEAK_BITS-1:0];
        end
        if (sv > fsv) begin
            vc = fsv;
        end else if (sv < -fsv) begin
            vc = -fsv;
        end else begin
            vc = sv;
        end
        n_peak = (i_pix.frame_start || mag_sat > r_peak) ? mag_sat : r_peak;
        o_job.offset = fhc_pkg::CW'(vc + fsv);
        o_job.tag    = i_pix.cell_tag;
        o_job.peak   = n_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (o_push) begin
            r_peak <= n_peak;
        end
    end
endmodule
`default_nettype wire

@@ rtl/fhc_queue.sv @@
// Two-entry queue of jobs between the front end and the back end.
// Depends on fhc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fhc_queue (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  fhc_pkg::t_job i_job,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output fhc_pkg::t_job o_job
);
    fhc_pkg::t_job r_mem [0:1];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into a full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from an empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
endmodule
`default_nettype wire

@@ rtl/fhc_back.sv @@
// Back end: restoring divider for the normalized fraction, colormap lookup
// and the output register. Depends on fhc_pkg and fhc_out_if.
`timescale 1ns / 1ps
`default_nettype none
module fhc_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [fhc_pkg::MODE_BITS-1:0]  i_mode,
    input  wire logic [fhc_pkg::FS_BITS-1:0]    i_full_scale,
    input  wire logic                           i_empty,
    input  fhc_pkg::t_job                       i_job,
    output logic                                o_pop,
    fhc_out_if.source                           o_pix
);
    localparam int F = fhc_pkg::FRACTION_BITS;
    localparam int RW = fhc_pkg::RW;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [RW-1:0]                 r_rem;
    logic [RW-1:0]                 r_dvs;
    logic [F:0]                    r_quo;
    logic [fhc_pkg::CNT_W-1:0]     r_cnt;
    logic [fhc_pkg::TAG_BITS-1:0]  r_tag;
    logic [fhc_pkg::PEAK_BITS-1:0] r_peak;
    logic                          r_out_valid;
    fhc_pkg::t_rgb                 r_rgb;
    logic [fhc_pkg::PEAK_BITS-1:0] r_out_peak;

    logic          done;
    logic          write_out;
    logic [F:0]    t;
    logic signed [F+3:0] jr;
    logic signed [F+3:0] jg;
    logic signed [F+3:0] jb;
    logic signed [F+3:0] dev;
    logic [F:0]    cr;
    logic [F:0]    cg;
    logic [F:0]    cb;
    logic [F+2:0]  p;
    logic [1:0]    idx;
    logic [F-1:0]  f;
    logic [F:0]    fc;
    fhc_pkg::t_rgb lo;
    fhc_pkg::t_rgb hi;
    fhc_pkg::t_rgb rgb_jet;
    fhc_pkg::t_rgb rgb_stop;
    fhc_pkg::t_rgb n_rgb;

    function automatic logic [F:0] clamp_frac(input logic signed [F+3:0] x);
        logic [F:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > (F+4)'(1 << F)) begin
            res = (F+1)'(1 << F);
        end else begin
            res = x[F:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] to_byte(input logic [F:0] x);
        logic [F+8:0] prod;
        prod = (F+9)'(x) * (F+9)'(255);
        return prod[F+7:F];
    endfunction

    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [F-1:0] fr);
        logic [F+9:0] acc;
        acc = (F+10)'((F+1)'(1 << F) - (F+1)'(fr)) * (F+10)'(a)
            + (F+10)'(fr) * (F+10)'(b);
        return acc[F+7:F];
    endfunction

    assign done      = (r_cnt == fhc_pkg::CNT_W'(fhc_pkg::STEPS));
    assign write_out = (r_state == S_DIV) && done && (!r_out_valid || o_pix.ready);
    assign o_pop     = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (write_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        t = (i_full_scale == '0) ? '0 : r_quo;

        jr  = (F+4)'(t) * (F+4)'(4) - (F+4)'(1 << F);
        dev = (F+4)'(t) - (F+4)'(1 << (F - 1));
        if (dev < 0) begin
            dev = -dev;
        end
        jg = dev * (F+4)'(4) - (F+4)'(1 << F);
        jb = (F+4)'(3 << F) - (F+4)'(t) * (F+4)'(4);
        cr = clamp_frac(jr);
        cg = clamp_frac(jg);
        cb = clamp_frac(jb);
        rgb_jet = '{to_byte(cr), to_byte(cg), to_byte(cb)};

        p   = (F+3)'(t) << 2;
        idx = p[F+1:F];
        f   = p[F-1:0];
        fc  = (F+1)'(f);
        if (i_mode == fhc_pkg::MODE_PLASMA) begin
            lo = fhc_pkg::PLASMA[3'(idx)];
            hi = fhc_pkg::PLASMA[3'(idx) + 3'd1];
        end else begin
            lo = fhc_pkg::VIRIDIS[3'(idx)];
            hi = fhc_pkg::VIRIDIS[3'(idx) + 3'd1];
        end
        if (t[F]) begin
            rgb_stop = (i_mode == fhc_pkg::MODE_PLASMA) ? fhc_pkg::PLASMA[4]
                                                        : fhc_pkg::VIRIDIS[4];
        end else begin
            rgb_stop = '{blend(lo.r, hi.r, fc[F-1:0]), blend(lo.g, hi.g, fc[F-1:0]),
                         blend(lo.b, hi.b, fc[F-1:0])};
        end

        case (i_mode)
            fhc_pkg::MODE_VIRIDIS, fhc_pkg::MODE_PLASMA: n_rgb = rgb_stop;
            default: n_rgb = rgb_jet;
        endcase
        if (r_tag == fhc_pkg::TAG_GREY) begin
            n_rgb = fhc_pkg::RGB_GREY;
        end else if (r_tag == fhc_pkg::TAG_BLUE) begin
            n_rgb = fhc_pkg::RGB_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem  <= RW'(i_job.offset) << (F - 1);
            r_dvs  <= RW'(i_full_scale) << F;
            r_quo  <= '0;
            r_tag  <= i_job.tag;
            r_peak <= i_job.peak;
        end else if (r_state == S_DIV && !done) begin
            if (r_rem >= r_dvs) begin
                r_rem <= r_rem - r_dvs;
                r_quo <= {r_quo[F-1:0], 1'b1};
            end else begin
                r_quo <= {r_quo[F-1:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
        end
        if (write_out) begin
            r_rgb      <= n_rgb;
            r_out_peak <= r_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV && !done) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (write_out) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pix.valid          = r_out_valid;
    assign o_pix.red            = r_rgb.r;
    assign o_pix.green          = r_rgb.g;
    assign o_pix.blue           = r_rgb.b;
    assign o_pix.peak_magnitude = r_out_peak;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= fhc_pkg::CNT_W'(fhc_pkg::STEPS)) else $error("divider overran");
    a_write_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        write_out |-> r_state == S_DIV && done) else $error("early result write");
    a_hold_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_pix.ready |=> r_out_valid && $stable(r_rgb)
        && $stable(r_out_peak)) else $error("stalled pixel beat changed");
endmodule
`default_nettype wire

@@ rtl/field_heatmap_colormap.sv @@
// The 11-step restoring divider that forms the normalized fraction handles one
// sample at a time: the back end takes the next job from the queue only once
// the pixel of the last one has been written to the output register.
// A two-entry queue lets the next samples enter while a pixel waits.
// Reset is synchronous: it empties the queue, clears the frame peak, selects
// the classic jet map and sets full_scale to 32767.
`timescale 1ns / 1ps
`default_nettype none
module field_heatmap_colormap (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [fhc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [fhc_pkg::FS_BITS-1:0]         i_cfg_data,
    fhc_in_if.sink                                   i_pix,
    fhc_out_if.source                                o_pix
);
    logic [fhc_pkg::MODE_BITS-1:0] r_mode;
    logic [fhc_pkg::FS_BITS-1:0]   r_fs;
    logic                          push;
    logic                          pop;
    logic                          full;
    logic                          empty;
    fhc_pkg::t_job                 job_in;
    fhc_pkg::t_job                 job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= fhc_pkg::MODE_JET;
            r_fs   <= fhc_pkg::FS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fhc_pkg::CFG_MODE: r_mode <= i_cfg_data[fhc_pkg::MODE_BITS-1:0];
                fhc_pkg::CFG_FS:   r_fs   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fhc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_full_scale (r_fs),
        .i_full       (full),
        .o_push       (push),
        .o_job        (job_in)
    );

    fhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    fhc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_full_scale (r_fs),
        .i_empty      (empty),
        .i_job        (job_out),
        .o_pop        (pop),
        .o_pix        (o_pix)
    );
endmodule
`default_nettype wire
